### design/rra_pkg.sv
`default_nettype none
package rra_pkg;

    localparam int RRA_MAX_ATOMS = 64;
    localparam int TOT_MAX = 2097151;
    localparam int TOT_MIN = -2097152;
    localparam int BAND_RESET = 410;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       store;
        logic       clr;
        logic       sum_issue;
        logic       tot;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic       dsub;
        logic       mul_go;
        logic [1:0] coord;
        logic [1:0] part;
        logic       cmp;
        logic       first;
        logic       emit;
        logic       eor;
        logic       final_prev;
        logic       mol_end;
    } rra_cmd_t;

    typedef struct packed {
        logic started;
        logic new_res;
        logic last;
        logic out_free;
    } rra_sts_t;

endpackage
`default_nettype wire

### design/rra_dpath.sv
`default_nettype none
module rra_dpath import rra_pkg::*; #(
    parameter int MAX_RES_ATOMS = RRA_MAX_ATOMS,
    parameter int AW = (MAX_RES_ATOMS > 1) ? $clog2(MAX_RES_ATOMS) : 1,
    parameter int CW = $clog2(MAX_RES_ATOMS + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [103:0]  s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          cfg_valid,
    input  wire logic [14:0]   cfg_data,
    input  wire rra_cmd_t      cmd,
    input  wire logic [AW-1:0] rd_addr,
    output rra_sts_t           sts,
    output logic [CW-1:0]      n_cnt,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [87:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    localparam int QSW = (16 + CW > 23) ? 16 + CW : 23;
    localparam int GSW = 24 + CW;
    localparam int WSW = 40 + CW;
    localparam int CEW = WSW + 1;
    localparam int DW  = CEW + 1;
    localparam int HW  = (DW + 1) / 2;
    localparam int DSW = 2 * DW + 2;
    localparam int DVW = 22;

    logic [14:0] band_reg;
    logic [15:0] rn_reg;
    logic [15:0] q_in_reg;
    logic [23:0] x_in_reg, y_in_reg, z_in_reg;
    logic        last_reg;
    logic [15:0] atom_cnt_reg, res_cnt_reg, first_reg, count_reg, cur_reg;
    logic        started_reg;

    logic [87:0] mem [MAX_RES_ATOMS];
    logic [87:0] rd_q_reg;

    logic                  v1_reg, v2_reg;
    logic signed [QSW-1:0] qacc_reg;
    logic signed [GSW-1:0] gacc_reg [3];
    logic signed [WSW-1:0] wacc_reg [3];
    logic signed [39:0]    prod_w_reg [3];
    logic signed [21:0]    tot_reg;
    logic                  geo_reg;

    logic [WSW-1:0]        dq_reg;
    logic [DVW-1:0]        rem_reg, dvs_reg;
    logic                  neg_reg;
    logic signed [CEW-1:0] centre_reg [3];

    logic [DW-1:0]     amag_reg [3];
    logic [2*HW-1:0]   prod_reg;
    logic              pv_reg;
    logic [1:0]        pp_reg;
    logic [DSW-1:0]    dist_reg, best_d_reg;
    logic [AW-1:0]     best_i_reg;

    logic [15:0] out_ri_reg, out_first_reg, out_final_reg, out_rep_reg;
    logic [21:0] out_tot_reg;
    logic        out_ovf_reg, out_eor_reg, m_tvalid_reg;

    logic               opening;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [23:0] rd_c [3];
    logic signed [15:0] rd_q;
    logic signed [21:0] tot_sat;
    logic signed [22:0] tot23, band23;
    logic               geo_next;
    logic signed [WSW-1:0] dvd;
    logic [DVW:0]       div_t;
    logic               div_ge;
    logic [DW-HW-1:0]   ah;
    logic [HW-1:0]      al, ah_ext, op_a, op_b;
    logic [DW-1:0]      amag_sel;
    logic [DSW-1:0]     term;
    logic signed [CEW:0] diff [3];

    assign opening = !started_reg;
    assign wr_addr = opening ? '0 : count_reg[AW-1:0];
    assign wr_en   = cmd.store && (opening || (count_reg < 16'(MAX_RES_ATOMS)));
    assign n_cnt   = (count_reg >= 16'(MAX_RES_ATOMS)) ? CW'(MAX_RES_ATOMS)
                                                       : count_reg[CW-1:0];

    assign rd_c[0] = rd_q_reg[23:0];
    assign rd_c[1] = rd_q_reg[47:24];
    assign rd_c[2] = rd_q_reg[71:48];
    assign rd_q    = rd_q_reg[87:72];

    assign sts.started  = started_reg;
    assign sts.new_res  = rn_reg != cur_reg;
    assign sts.last     = last_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        if (qacc_reg > QSW'(TOT_MAX)) begin
            tot_sat = 22'(TOT_MAX);
        end else if (qacc_reg < QSW'(TOT_MIN)) begin
            tot_sat = 22'(TOT_MIN);
        end else begin
            tot_sat = qacc_reg[21:0];
        end
    end

    assign tot23    = {tot_sat[21], tot_sat};
    assign band23   = {8'b0, band_reg};
    assign geo_next = ((tot23 > -band23) && (tot23 < band23)) || (tot_sat == '0);

    assign dvd    = geo_reg ? WSW'(gacc_reg[cmd.coord]) : wacc_reg[cmd.coord];
    assign div_t  = {rem_reg, dq_reg[WSW-1]};
    assign div_ge = div_t >= {1'b0, dvs_reg};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = (CEW+1)'(centre_reg[c]) - (CEW+1)'(rd_c[c]);
        end
    end

    // split square: a^2 = ah^2 << 2HW + 2 ah al << HW + al^2
    assign amag_sel = amag_reg[cmd.coord];
    assign al     = amag_sel[HW-1:0];
    assign ah     = amag_sel[DW-1:HW];
    assign ah_ext = HW'(ah);
    assign op_a   = (cmd.part == 2'd0) ? al : ah_ext;
    assign op_b   = (cmd.part == 2'd2) ? ah_ext : al;

    always_comb begin
        case (pp_reg)
            2'd0:    term = DSW'(prod_reg);
            2'd1:    term = DSW'(prod_reg) << (HW + 1);
            2'd2:    term = DSW'(prod_reg) << (2 * HW);
            default: term = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {q_in_reg, z_in_reg, y_in_reg, x_in_reg};
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg     <= 15'(BAND_RESET);
            atom_cnt_reg <= '0;
            res_cnt_reg  <= '0;
            first_reg    <= '0;
            count_reg    <= '0;
            cur_reg      <= '0;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            pv_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                band_reg <= cfg_data;
            end
            if (cmd.capture) begin
                atom_cnt_reg <= atom_cnt_reg + 16'd1;
            end
            if (cmd.store) begin
                if (opening) begin
                    res_cnt_reg <= res_cnt_reg + 16'd1;
                    first_reg   <= atom_cnt_reg;
                    cur_reg     <= rn_reg;
                    started_reg <= 1'b1;
                    count_reg   <= 16'd1;
                end else if (count_reg != 16'hFFFF) begin
                    count_reg <= count_reg + 16'd1;
                end
            end
            if (cmd.emit) begin
                started_reg  <= 1'b0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cmd.mol_end) begin
                atom_cnt_reg <= '0;
                res_cnt_reg  <= '0;
            end
            v1_reg <= cmd.sum_issue;
            v2_reg <= v1_reg;
            pv_reg <= cmd.mul_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rn_reg   <= s_tdata[15:0];
            q_in_reg <= s_tdata[31:16];
            x_in_reg <= s_tdata[55:32];
            y_in_reg <= s_tdata[79:56];
            z_in_reg <= s_tdata[103:80];
            last_reg <= s_tlast;
        end

        // accumulation pass: geometric sums from the read stage, weighted one stage on
        if (cmd.clr) begin
            qacc_reg <= '0;
            for (int c = 0; c < 3; c++) begin
                gacc_reg[c] <= '0;
                wacc_reg[c] <= '0;
            end
        end else begin
            if (v1_reg) begin
                qacc_reg <= qacc_reg + QSW'(rd_q);
                for (int c = 0; c < 3; c++) begin
                    gacc_reg[c] <= gacc_reg[c] + GSW'(rd_c[c]);
                end
            end
            if (v2_reg) begin
                for (int c = 0; c < 3; c++) begin
                    wacc_reg[c] <= wacc_reg[c] + WSW'(prod_w_reg[c]);
                end
            end
        end
        for (int c = 0; c < 3; c++) begin
            prod_w_reg[c] <= rd_q * rd_c[c];
        end

        if (cmd.tot) begin
            tot_reg <= tot_sat;
            geo_reg <= geo_next;
        end

        // restoring divider on magnitudes, one quotient bit per cycle
        if (cmd.div_init) begin
            dq_reg  <= dvd[WSW-1] ? WSW'(-dvd) : WSW'(dvd);
            rem_reg <= '0;
            dvs_reg <= geo_reg ? DVW'(n_cnt)
                               : (tot_reg[21] ? DVW'(-tot_reg) : DVW'(tot_reg));
            neg_reg <= dvd[WSW-1] ^ (!geo_reg && tot_reg[21]);
        end else if (cmd.div_step) begin
            rem_reg <= div_ge ? DVW'(div_t - {1'b0, dvs_reg}) : DVW'(div_t);
            dq_reg  <= {dq_reg[WSW-2:0], div_ge};
        end
        if (cmd.div_end) begin
            centre_reg[cmd.coord] <= neg_reg ? -$signed({1'b0, dq_reg})
                                             : $signed({1'b0, dq_reg});
        end

        if (cmd.dsub) begin
            for (int c = 0; c < 3; c++) begin
                amag_reg[c] <= diff[c][CEW] ? DW'(-diff[c]) : DW'(diff[c]);
            end
            dist_reg <= '0;
        end else if (pv_reg) begin
            dist_reg <= dist_reg + term;
        end
        prod_reg <= op_a * op_b;
        pp_reg   <= cmd.part;

        if (cmd.cmp && (cmd.first || (dist_reg < best_d_reg))) begin
            best_d_reg <= dist_reg;
            best_i_reg <= rd_addr;
        end

        if (cmd.emit) begin
            out_ri_reg    <= res_cnt_reg;
            out_first_reg <= first_reg;
            out_final_reg <= cmd.final_prev ? atom_cnt_reg - 16'd1 : atom_cnt_reg;
            out_tot_reg   <= tot_reg;
            out_rep_reg   <= first_reg + 16'(best_i_reg);
            out_ovf_reg   <= count_reg > 16'(MAX_RES_ATOMS);
            out_eor_reg   <= cmd.eor;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b0, out_rep_reg, out_tot_reg, out_final_reg, out_first_reg, out_ri_reg};
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_eor_reg;

endmodule
`default_nettype wire

### design/rra_ctrl.sv
`default_nettype none
module rra_ctrl import rra_pkg::*; #(
    parameter int MAX_RES_ATOMS = RRA_MAX_ATOMS,
    parameter int AW = (MAX_RES_ATOMS > 1) ? $clog2(MAX_RES_ATOMS) : 1,
    parameter int CW = $clog2(MAX_RES_ATOMS + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire rra_sts_t      sts,
    input  wire logic [CW-1:0] n_cnt,
    output rra_cmd_t           cmd,
    output logic [AW-1:0]      rd_addr
);

    localparam int WSW = 40 + CW;
    localparam int BW  = $clog2(WSW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_STORE, S_CLR, S_SUM, S_SUMD, S_TOT, S_DINIT,
        S_DSTEP, S_DEND, S_DRD, S_DSUB, S_DMUL, S_DFL, S_DCMP, S_EMIT
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] idx_reg;
    logic [BW-1:0] bit_reg;
    logic [1:0]    coord_reg, part_reg;
    logic          drain_reg;
    logic          kind_last_reg;   // closing on the last atom rather than a residue change

    logic idx_end;
    assign idx_end = idx_reg == (n_cnt - CW'(1));
    assign rd_addr = idx_reg[AW-1:0];

    always_comb begin
        cmd          = '0;
        cmd.coord    = coord_reg;
        cmd.part     = part_reg;
        cmd.first    = idx_reg == '0;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_STORE: cmd.store     = 1'b1;
            S_CLR:   cmd.clr       = 1'b1;
            S_SUM:   cmd.sum_issue = 1'b1;
            S_TOT:   cmd.tot       = 1'b1;
            S_DINIT: cmd.div_init  = 1'b1;
            S_DSTEP: cmd.div_step  = 1'b1;
            S_DEND:  cmd.div_end   = 1'b1;
            S_DSUB:  cmd.dsub      = 1'b1;
            S_DMUL:  cmd.mul_go    = 1'b1;
            S_DCMP:  cmd.cmp       = 1'b1;
            S_EMIT: begin
                cmd.emit       = sts.out_free;
                cmd.eor        = kind_last_reg || !sts.last;
                cmd.final_prev = !kind_last_reg;
                cmd.mol_end    = sts.out_free && kind_last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            bit_reg       <= '0;
            coord_reg     <= '0;
            part_reg      <= '0;
            drain_reg     <= 1'b0;
            kind_last_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (sts.started && sts.new_res) begin
                        kind_last_reg <= 1'b0;
                        state_reg     <= S_CLR;
                    end else begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (sts.last) begin
                        kind_last_reg <= 1'b1;
                        state_reg     <= S_CLR;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CLR: begin
                    idx_reg   <= '0;
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    if (idx_end) begin
                        drain_reg <= 1'b0;
                        state_reg <= S_SUMD;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                S_SUMD: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= S_TOT;
                    end
                end
                S_TOT: begin
                    coord_reg <= '0;
                    state_reg <= S_DINIT;
                end
                S_DINIT: begin
                    bit_reg   <= '0;
                    state_reg <= S_DSTEP;
                end
                S_DSTEP: begin
                    if (bit_reg == BW'(WSW - 1)) begin
                        state_reg <= S_DEND;
                    end else begin
                        bit_reg <= bit_reg + BW'(1);
                    end
                end
                S_DEND: begin
                    if (coord_reg == 2'd2) begin
                        idx_reg   <= '0;
                        state_reg <= S_DRD;
                    end else begin
                        coord_reg <= coord_reg + 2'd1;
                        state_reg <= S_DINIT;
                    end
                end
                S_DRD: state_reg <= S_DSUB;
                S_DSUB: begin
                    coord_reg <= '0;
                    part_reg  <= '0;
                    state_reg <= S_DMUL;
                end
                S_DMUL: begin
                    if (part_reg == 2'd2) begin
                        part_reg <= '0;
                        if (coord_reg == 2'd2) begin
                            state_reg <= S_DFL;
                        end else begin
                            coord_reg <= coord_reg + 2'd1;
                        end
                    end else begin
                        part_reg <= part_reg + 2'd1;
                    end
                end
                S_DFL: state_reg <= S_DCMP;
                S_DCMP: begin
                    if (idx_end) begin
                        state_reg <= S_EMIT;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_DRD;
                    end
                end
                S_EMIT: begin
                    if (sts.out_free) begin
                        state_reg <= kind_last_reg ? S_IDLE : S_STORE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### design/residue_representative_atom.sv
`default_nettype none
// Residue representative atom finder. Atoms stream in on s_ (one per item); a change of
// residue number or tlast closes the open residue and one result item leaves on m_ per
// closed residue (two when a new residue starts on the last atom). A closed residue of n
// stored atoms (n at most MAX_RES_ATOMS) takes one memory sweep to sum, three bit-serial
// divisions for the centre, and a distance search over the n atoms, where one multiplier
// forms each squared distance from nine partial products. Input items are taken only while
// no residue is being closed. The neutral band register is written over cfg_valid/cfg_data
// and must be changed only while the block is idle.
module residue_representative_atom import rra_pkg::*; #(
    parameter int MAX_RES_ATOMS = RRA_MAX_ATOMS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // residue_number, charge, x_coord, y_coord, z_coord
    input  wire logic [103:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [14:0]  cfg_data,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // residue_index, first_atom, final_atom, total_charge, representative_atom, 2 pad
    output logic [87:0]       m_tdata,
    // overflow
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int AW = (MAX_RES_ATOMS > 1) ? $clog2(MAX_RES_ATOMS) : 1;
    localparam int CW = $clog2(MAX_RES_ATOMS + 1);

    rra_cmd_t      cmd;
    rra_sts_t      sts;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] n_cnt;

    assign cfg_ready = 1'b1;

    rra_ctrl #(
        .MAX_RES_ATOMS(MAX_RES_ATOMS), .AW(AW), .CW(CW)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .n_cnt(n_cnt), .cmd(cmd), .rd_addr(rd_addr)
    );

    rra_dpath #(
        .MAX_RES_ATOMS(MAX_RES_ATOMS), .AW(AW), .CW(CW)
    ) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cmd(cmd), .rd_addr(rd_addr),
        .sts(sts), .n_cnt(n_cnt), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import rra_pkg::*;

    localparam int DEPTH = RRA_MAX_ATOMS;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE = 60;

    typedef struct {
        bit [15:0]        rn;
        bit signed [15:0] q;
        bit signed [23:0] x;
        bit signed [23:0] y;
        bit signed [23:0] z;
        bit               last;
    } atom_t;

    typedef struct {
        bit [15:0] res_idx;
        bit [15:0] first;
        bit [15:0] final_no;
        bit [21:0] tot;
        bit [15:0] rep;
        bit        ovf;
        bit        eor;
    } residue_t;

    class residue_scoreboard;
        int               errors;
        residue_t         pending_q[$];
        bit [14:0]        band;
        longint           xs[DEPTH];
        longint           ys[DEPTH];
        longint           zs[DEPTH];
        longint           qs[DEPTH];
        bit [15:0]        cur_rn;
        bit               open;
        bit [15:0]        atom_no;
        bit [15:0]        res_no;
        bit [15:0]        first_no;
        bit [15:0]        count;

        function new();
            errors = 0;
            band = 15'(BAND_RESET);
            open = 0;
            cur_rn = 0;
            atom_no = 0;
            res_no = 0;
            first_no = 0;
            count = 0;
        endfunction

        function bit [127:0] sq(longint d);
            bit [127:0] a;
            a = (d < 0) ? 128'(-d) : 128'(d);
            return a * a;
        endfunction

        function residue_t close_residue(bit [15:0] last_no);
            residue_t r;
            int n;
            longint tot, sx, sy, sz, cx, cy, cz;
            bit [127:0] d, bestd;
            int best;
            n = (count < DEPTH) ? count : DEPTH;
            tot = 0; sx = 0; sy = 0; sz = 0;
            best = 0;
            bestd = 0;
            for (int i = 0; i < n; i++) tot += qs[i];
            if (tot > TOT_MAX) tot = TOT_MAX;
            if (tot < TOT_MIN) tot = TOT_MIN;
            if ((tot > -longint'(band) && tot < longint'(band)) || tot == 0) begin
                for (int i = 0; i < n; i++) begin
                    sx += xs[i]; sy += ys[i]; sz += zs[i];
                end
                cx = sx / n; cy = sy / n; cz = sz / n;
            end else begin
                for (int i = 0; i < n; i++) begin
                    sx += qs[i] * xs[i]; sy += qs[i] * ys[i]; sz += qs[i] * zs[i];
                end
                cx = sx / tot; cy = sy / tot; cz = sz / tot;
            end
            for (int i = 0; i < n; i++) begin
                d = sq(cx - xs[i]) + sq(cy - ys[i]) + sq(cz - zs[i]);
                if (i == 0 || d < bestd) begin
                    bestd = d;
                    best = i;
                end
            end
            r.res_idx = res_no;
            r.first = first_no;
            r.final_no = last_no;
            r.tot = tot[21:0];
            r.rep = first_no + 16'(best);
            r.ovf = (count > DEPTH);
            r.eor = 0;
            open = 0;
            return r;
        endfunction

        function void note_atom(atom_t a);
            int made;
            made = 0;
            atom_no = atom_no + 1;
            if (open && a.rn != cur_rn) begin
                pending_q.push_back(close_residue(atom_no - 1));
                made++;
            end
            if (!open) begin
                res_no = res_no + 1;
                first_no = atom_no;
                count = 0;
                cur_rn = a.rn;
                open = 1;
            end
            if (count < DEPTH) begin
                xs[count] = a.x; ys[count] = a.y; zs[count] = a.z; qs[count] = a.q;
            end
            if (count != 16'hffff) count = count + 1;
            if (a.last) begin
                pending_q.push_back(close_residue(atom_no));
                made++;
                atom_no = 0;
                res_no = 0;
            end
            if (made > 0) pending_q[$].eor = 1;
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_residue(residue_t g);
            residue_t e;
            if (pending_q.size() == 0) begin
                report("unexpected item", 0, 0);
                return;
            end
            e = pending_q.pop_front();
            if (g.res_idx != e.res_idx) report("residue_index", g.res_idx, e.res_idx);
            if (g.first != e.first) report("first_atom", g.first, e.first);
            if (g.final_no != e.final_no) report("final_atom", g.final_no, e.final_no);
            if (g.tot != e.tot) report("total_charge", g.tot, e.tot);
            if (g.rep != e.rep) report("representative_atom", g.rep, e.rep);
            if (g.ovf != e.ovf) report("overflow", g.ovf, e.ovf);
            if (g.eor != e.eor) report("end_of_run", g.eor, e.eor);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         s_tlast = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [14:0]  cfg_data = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [87:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    residue_scoreboard sb = new();
    int  quiet_cycles = 0;
    int  items_sent = 0;
    bit  calm = 0;
    bit  hold_off = 0;
    bit  [15:0] next_rn = 0;

    always #4 aclk = ~aclk;

    residue_representative_atom u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // monitors: values read here are those from before the edge
    always @(posedge aclk) begin
        atom_t a;
        residue_t g;
        if (aresetn && s_tvalid && s_tready) begin
            a.rn = s_tdata[15:0];
            a.q = s_tdata[31:16];
            a.x = s_tdata[55:32];
            a.y = s_tdata[79:56];
            a.z = s_tdata[103:80];
            a.last = s_tlast;
            sb.note_atom(a);
        end
        if (aresetn && m_tvalid && m_tready) begin
            g.res_idx = m_tdata[15:0];
            g.first = m_tdata[31:16];
            g.final_no = m_tdata[47:32];
            g.tot = m_tdata[69:48];
            g.rep = m_tdata[85:70];
            g.ovf = m_tuser;
            g.eor = m_tlast;
            sb.check_residue(g);
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else if (calm) m_tready <= 1;
        else m_tready <= ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task send_atom(atom_t a);
        if (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {a.z, a.y, a.x, a.q, a.rn};
        s_tlast <= a.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task write_band(bit [14:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        sb.band = v;
    endtask

    function atom_t make_atom(bit [15:0] rn, bit last);
        atom_t a;
        int k;
        a.rn = rn;
        a.last = last;
        k = $urandom_range(0, 9);
        if (k < 5) a.q = 16'($signed($urandom_range(0, 800)) - 400);
        else if (k < 9) a.q = 16'($urandom);
        else a.q = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 3) == 0) begin
            a.x = 24'($signed($urandom_range(0, 8000)) - 4000);
            a.y = 24'($signed($urandom_range(0, 8000)) - 4000);
            a.z = 24'($signed($urandom_range(0, 8000)) - 4000);
        end else begin
            a.x = 24'($urandom);
            a.y = 24'($urandom);
            a.z = 24'($urandom);
        end
        return a;
    endfunction

    function atom_t fixed_atom(bit [15:0] rn, int q, int c, bit last);
        atom_t a;
        a.rn = rn; a.q = 16'(q); a.x = 24'(c); a.y = 24'(c); a.z = 24'(c); a.last = last;
        return a;
    endfunction

    task send_molecule;
        int nres, sz;
        nres = $urandom_range(1, 6);
        for (int r = 0; r < nres; r++) begin
            next_rn = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : next_rn + 16'($urandom_range(1, 5));
            sz = $urandom_range(0, 99);
            if (sz < 2) sz = $urandom_range(64, 70);
            else if (sz < 8) sz = $urandom_range(9, 20);
            else sz = $urandom_range(1, 8);
            for (int i = 0; i < sz; i++)
                send_atom(make_atom(next_rn, (r == nres - 1) && (i == sz - 1)));
        end
    endtask

    task random_phase(int n_items);
        int stop;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) == 0)
                send_atom(make_atom(16'($urandom), $urandom_range(0, 7) == 0));
            else
                send_molecule();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, single-atom molecules, two results on one item
        send_atom(fixed_atom(16'h0000, 32767, 8388607, 1));
        send_atom(fixed_atom(16'hffff, -32768, -8388608, 1));
        send_atom(fixed_atom(16'h0010, 0, 0, 0));
        send_atom(fixed_atom(16'h0010, 1000, 8388607, 0));
        send_atom(fixed_atom(16'h0010, -32768, -8388608, 0));
        send_atom(fixed_atom(16'h0011, 200, 5, 1));
        // equal distances: earliest atom wins
        send_atom(fixed_atom(16'h0020, 0, 100, 0));
        send_atom(fixed_atom(16'h0020, 0, -100, 0));
        send_atom(fixed_atom(16'h0021, 32767, -8388608, 0));
        send_atom(fixed_atom(16'h0021, 32767, 8388607, 1));
        drain();

        // zero band: a zero total still takes the geometric centre
        write_band(15'd0);
        send_atom(fixed_atom(16'h0030, 5, 1000, 0));
        send_atom(fixed_atom(16'h0030, -5, -3000, 0));
        send_atom(fixed_atom(16'h0030, 0, 7, 1));
        send_atom(fixed_atom(16'h0031, 1, 40, 0));
        send_atom(fixed_atom(16'h0031, 2, -40, 1));
        random_phase(200);
        drain();

        write_band(15'h7fff);
        // receiver stalls for a long stretch while atoms keep coming
        fork
            begin
                hold_off = 1;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
        join_none
        random_phase(250);
        drain();

        write_band(15'd410);
        calm = 1;
        random_phase(250);
        calm = 0;
        drain();

        write_band(15'($urandom_range(1, 4000)));
        random_phase(250);
        drain();

        write_band(15'($urandom));
        random_phase(250);
        if (!sb.open) send_atom(make_atom(next_rn + 1, 0));
        send_atom(make_atom(next_rn + 2, 1));
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### residue_representative_atom.f
design/rra_pkg.sv
design/rra_dpath.sv
design/rra_ctrl.sv
design/residue_representative_atom.sv
dv/testbench.sv
